### rtl/core/deq_pkg.sv
// Shared types and codes for the double-ended queue core.
package deq_pkg;

    localparam int WORD_W = 32;
    localparam int OCC_W  = 5;

    typedef logic signed [WORD_W-1:0] deq_word_t;
    typedef logic [OCC_W-1:0]         deq_occ_t;
    typedef logic [2:0]               deq_req_code_t;
    typedef logic [1:0]               deq_status_t;

    localparam deq_req_code_t REQ_PUSH_FRONT = 3'd0;
    localparam deq_req_code_t REQ_PUSH_BACK  = 3'd1;
    localparam deq_req_code_t REQ_POP_FRONT  = 3'd2;
    localparam deq_req_code_t REQ_POP_BACK   = 3'd3;
    localparam deq_req_code_t REQ_CLEAR      = 3'd4;

    localparam deq_status_t ST_OK    = 2'd0;
    localparam deq_status_t ST_EMPTY = 2'd1;
    localparam deq_status_t ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_CLEAR
    } deq_op_t;

    typedef struct packed {
        deq_req_code_t req_type;
        deq_word_t     push_value;
    } deq_req_t;

    typedef struct packed {
        deq_status_t status;
        deq_word_t   popped_value;
        logic        now_empty;
        deq_occ_t    occupancy;
    } deq_rsp_t;

    typedef struct packed {
        deq_op_t   op;
        deq_word_t value;
    } deq_cmd_t;

    typedef struct packed {
        logic      valid;
        deq_word_t data;
        deq_word_t carry;
    } deq_link_t;

endpackage

### rtl/core/deq_cell.sv
// One storage cell of the queue chain: entry, valid flag and back-value carry.
module deq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  deq_pkg::deq_cmd_t  cmd,
    input  deq_pkg::deq_link_t prev_link,
    input  deq_pkg::deq_link_t next_link,
    output deq_pkg::deq_link_t link
);

    logic              valid_reg;
    logic              valid_next;
    deq_pkg::deq_word_t data_reg;
    deq_pkg::deq_word_t data_next;
    deq_pkg::deq_word_t carry_reg;
    deq_pkg::deq_word_t carry_next;
    logic              is_last;

    assign is_last = valid_reg && !next_link.valid;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        case (cmd.op)
            deq_pkg::OP_PUSH_FRONT:
            begin
                valid_next = prev_link.valid;
                data_next  = prev_link.data;
            end
            deq_pkg::OP_PUSH_BACK:
            begin
                if (!valid_reg && prev_link.valid)
                begin
                    valid_next = 1'b1;
                    data_next  = cmd.value;
                end
            end
            deq_pkg::OP_POP_FRONT:
            begin
                valid_next = next_link.valid;
                data_next  = next_link.data;
            end
            deq_pkg::OP_POP_BACK:
            begin
                if (is_last)
                begin
                    valid_next = 1'b0;
                end
            end
            deq_pkg::OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // pass the back entry toward the front of the chain
    assign carry_next = is_last ? data_reg : next_link.carry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        carry_reg <= carry_next;
    end

    assign link.valid = valid_reg;
    assign link.data  = data_reg;
    assign link.carry = carry_reg;

endmodule

### rtl/core/double_ended_queue_core.sv
// Top level of the double-ended queue: request decode, count and cell chain.
// Response timing: push, pop front, clear, unused codes and pop back on an empty queue
// give their response in the cycle after the request transaction; other pop back
// requests respond only after the back value has swept along the cell chain.
// Throughput: one request per cycle while responses are taken, except that a pop back
// on a non-empty queue holds off the next request until its sweep of the back value
// along the cell chain to the front cell is done and its response is registered.
// Reset: rst_n clears the count, all cell valid flags and the response valid.
module double_ended_queue_core #(
    parameter int DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  deq_pkg::deq_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output deq_pkg::deq_rsp_t rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SWEEP = 2'b10
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   sweep_reg;
    logic [CNT_W-1:0]   sweep_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    deq_pkg::deq_rsp_t  rsp_reg;
    deq_pkg::deq_rsp_t  rsp_next;

    deq_pkg::deq_cmd_t  cmd;
    deq_pkg::deq_link_t links [0:DEPTH+1];
    logic [DEPTH-1:0]   cell_valid;

    logic               is_full;
    logic               is_empty;
    logic               slot_free;
    logic               accept;
    logic               has_result;
    deq_pkg::deq_status_t status;
    deq_pkg::deq_word_t popped;

    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE) && slot_free;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sweep_next     = sweep_reg;
        cmd.op         = deq_pkg::OP_NONE;
        cmd.value      = req.push_value;
        has_result     = 1'b0;
        status         = deq_pkg::ST_OK;
        popped         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    has_result = 1'b1;
                    unique case (req.req_type)
                        deq_pkg::REQ_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                status = deq_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.op     = deq_pkg::OP_PUSH_FRONT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        deq_pkg::REQ_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status = deq_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.op     = deq_pkg::OP_PUSH_BACK;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        deq_pkg::REQ_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                status = deq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.op     = deq_pkg::OP_POP_FRONT;
                                popped     = links[1].data;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        deq_pkg::REQ_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                status = deq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                has_result = 1'b0;
                                state_next = ST_SWEEP;
                                sweep_next = CNT_W'(DEPTH);
                            end
                        end
                        deq_pkg::REQ_CLEAR:
                        begin
                            cmd.op     = deq_pkg::OP_CLEAR;
                            count_next = '0;
                        end
                        default:
                        begin
                            status = deq_pkg::ST_OK;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (sweep_reg != '0)
                begin
                    sweep_next = sweep_reg - CNT_W'(1);
                end
                else if (slot_free)
                begin
                    cmd.op     = deq_pkg::OP_POP_BACK;
                    popped     = links[1].carry;
                    count_next = count_reg - CNT_W'(1);
                    has_result = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next        = rsp_valid_reg;
        rsp_next              = rsp_reg;
        if (has_result)
        begin
            rsp_valid_next         = 1'b1;
            rsp_next.status        = status;
            rsp_next.popped_value  = popped;
            rsp_next.now_empty     = (count_next == '0);
            rsp_next.occupancy     = deq_pkg::deq_occ_t'(count_next);
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sweep_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sweep_reg     <= sweep_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign links[0].valid       = 1'b1;
    assign links[0].data        = cmd.value;
    assign links[0].carry       = '0;
    assign links[DEPTH+1].valid = 1'b0;
    assign links[DEPTH+1].data  = '0;
    assign links[DEPTH+1].carry = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        deq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .prev_link (links[i]),
            .next_link (links[i+2]),
            .link      (links[i+1])
        );
        assign cell_valid[i] = links[i+1].valid;
    end

    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("entry count differs from occupied cells");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_sweep_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP |-> !req_ready)
        else $error("request taken during pop back sweep");

    a_sweep_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP |-> count_reg != '0)
        else $error("pop back sweep on empty queue");

    a_pop_back_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == deq_pkg::OP_POP_BACK |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop back did not shrink count");

endmodule
